@@ hdl/hce_pkg.sv @@
`default_nettype none
package hce_pkg;
	localparam int MaxPoints = 64;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = $clog2(MaxPoints + 1);

	typedef struct packed {
		logic        req_type;
		logic [5:0]  point_index;
		logic signed [31:0] position;
		logic signed [31:0] point_value;
		logic signed [31:0] in_tangent;
		logic signed [31:0] out_tangent;
	} hce_in_t;

	typedef struct packed {
		logic signed [31:0] curve_value;
		logic [2:0]  region;
	} hce_out_t;

	localparam logic [2:0] RegEmpty  = 3'd0;
	localparam logic [2:0] RegSingle = 3'd1;
	localparam logic [2:0] RegBelow  = 3'd2;
	localparam logic [2:0] RegInterp = 3'd3;
	localparam logic [2:0] RegAbove  = 3'd4;
	localparam logic [2:0] RegWrite  = 3'd5;
	localparam logic [2:0] RegSat    = 3'd6;

	localparam logic ReqWrite = 1'b0;
	localparam logic ReqEval  = 1'b1;

	localparam logic [0:0] AddrPointCount = 1'b0;

	typedef struct packed {
		logic                 start;
		logic signed [32:0]   num;
		logic signed [32:0]   den;
	} hce_div_req_t;
endpackage
`default_nettype wire

@@ hdl/hce_div.sv @@
`default_nettype none
// unsigned restoring divider, one quotient bit per cycle
// quotient = floor(num*65536/den), num <= den, so quotient <= 65536
// first step compares num against den unshifted to form the integer bit
module hce_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire hce_pkg::hce_div_req_t req,
	output logic        done,
	output logic [16:0] quot
);
	import hce_pkg::*;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [16:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        first;
	logic [33:0] trial;

	assign first = cnt_q == 5'd17;
	assign trial = (first ? {1'b0, rem_q} : {rem_q, 1'b0}) - {1'b0, den_q};
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
			end else if (busy_q) begin
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q  <= trial[32:0];
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q  <= first ? rem_q : {rem_q[31:0], 1'b0};
				quot_q <= {quot_q[15:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/hce_mem.sv @@
`default_nettype none
module hce_mem (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [5:0]  waddr,
	input  wire logic [63:0] wdata,
	input  wire logic [5:0]  raddr,
	output logic      [63:0] rdata
);
	logic [63:0] mem [64];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/hermite_curve_evaluator_core.sv @@
`default_nettype none
// channel | dir | signals
// in      | in  | in_valid, in_ready, in_word (hce_in_t)
// out     | out | out_valid, out_ready, out_word (hce_out_t)
// cfg     | in  | APB: psel penable pwrite paddr pwdata prdata pready
// One word at a time. An evaluate reads the position/value memory once
// per entry during the segment scan, then runs the divider and the
// multiply/accumulate steps. Reset clears control and point_count; the
// tables are undefined until written. A stalled output holds the word;
// no new word is taken until it is delivered.
module hermite_curve_evaluator_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire hce_pkg::hce_in_t in_word,
	output logic      out_valid,
	input  wire logic out_ready,
	output hce_pkg::hce_out_t out_word,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:2] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import hce_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_RD0   = 12'b000000000010,
		S_CHK0  = 12'b000000000100,
		S_CHKL  = 12'b000000001000,
		S_SCAN  = 12'b000000010000,
		S_SCANW = 12'b000000100000,
		S_TAN   = 12'b000001000000,
		S_TANW  = 12'b000010000000,
		S_DIV   = 12'b000100000000,
		S_MUL   = 12'b001000000000,
		S_SUM   = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [6:0] pcount_q;
	logic [6:0] n;
	hce_in_t req_q;

	logic        pv_we, tg_we;
	logic [5:0]  pv_ra, tg_ra;
	logic [63:0] pv_rd, tg_rd;

	logic [5:0]  idx_q;
	logic signed [31:0] p0_q, v0_q, first_q, p1_q, v1_q, m0_q, m1_q;
	logic        phase_q;
	logic [3:0]  mstep_q;
	logic signed [31:0] q;
	hce_div_req_t dreq;
	logic        ddone;
	logic [16:0] dquot;
	logic [16:0] u_q;
	logic [33:0] t2_q;
	logic signed [31:0] h00_q, h01_q, h10_q, h11_q;
	logic signed [65:0] s_q;
	logic signed [63:0] prod;
	logic signed [33:0] ma, mb;
	logic [52:0] hx;

	assign pready = 1'b1;
	assign prdata = {25'd0, pcount_q};
	assign n = (pcount_q > 7'(MaxPoints)) ? 7'(MaxPoints) : pcount_q;
	assign q = req_q.position;
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign hx = 53'(t2_q) << 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pcount_q <= '0;
		else if (psel && penable && pwrite && paddr[2] == AddrPointCount)
			pcount_q <= pwdata[6:0];
	end

	assign pv_we = in_valid && in_ready && in_word.req_type == ReqWrite;
	assign tg_we = pv_we;

	hce_mem u_pv (.clk, .we(pv_we), .waddr(in_word.point_index),
		.wdata({in_word.position, in_word.point_value}), .raddr(pv_ra), .rdata(pv_rd));
	hce_mem u_tg (.clk, .we(tg_we), .waddr(in_word.point_index),
		.wdata({in_word.in_tangent, in_word.out_tangent}), .raddr(tg_ra), .rdata(tg_rd));
	hce_div u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quot(dquot));

	always_comb begin
		pv_ra = idx_q;
		tg_ra = idx_q;
		dreq.start = (state_q == S_TANW) && phase_q;
		dreq.num = 33'(q) - 33'(p0_q);
		dreq.den = 33'(p1_q) - 33'(p0_q);
	end

	// one shared multiplier, sequenced by mstep_q
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (mstep_q)
			4'd0: begin ma = 34'(u_q); mb = 34'(u_q); end
			4'd1: begin ma = 34'(t2_q[32:0]); mb = 34'(u_q); end
			4'd2: begin ma = 34'(h00_q); mb = 34'(v0_q); end
			4'd3: begin ma = 34'(h10_q); mb = 34'(m0_q); end
			4'd4: begin ma = 34'(h01_q); mb = 34'(v1_q); end
			4'd5: begin ma = 34'(h11_q); mb = 34'(m1_q); end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = 64'(ma * mb);
	end

	function automatic logic [31:0] rnd48(input logic [52:0] x);
		logic [52:0] r;
		r = (x + 53'(1 << 17)) >> 18;
		return r[31:0];
	endfunction

	logic signed [65:0] sfin;
	logic signed [35:0] res;
	assign sfin = s_q + 66'sd536870912;
	assign res = 36'(sfin >>> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			phase_q <= 1'b0;
			mstep_q <= '0;
			idx_q <= '0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					req_q <= in_word;
					if (in_word.req_type == ReqWrite) begin
						out_word <= '{curve_value: '0, region: RegWrite};
						out_valid <= 1'b1;
					end else if (n == 7'd0) begin
						out_word <= '{curve_value: '0, region: RegEmpty};
						out_valid <= 1'b1;
					end else begin
						idx_q <= '0;
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					idx_q <= 6'(n - 7'd1);
					state_q <= S_CHK0;
				end
				S_CHK0: begin
					first_q <= pv_rd[63:32];
					v0_q <= pv_rd[31:0];
					if (n == 7'd1) begin
						out_word <= '{curve_value: pv_rd[31:0], region: RegSingle};
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else
						state_q <= S_CHKL;
				end
				S_CHKL: begin
					if (q <= first_q) begin
						out_word <= '{curve_value: v0_q, region: RegBelow};
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (!(q < $signed(pv_rd[63:32]))) begin
						out_word <= '{curve_value: pv_rd[31:0], region: RegAbove};
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= '0;
						phase_q <= 1'b0;
						state_q <= S_SCANW;
					end
				end
				S_SCANW: state_q <= S_SCAN;
				S_SCAN: begin
					// pv_rd holds entry idx_q
					if (!phase_q) begin
						p0_q <= pv_rd[63:32];
						v0_q <= pv_rd[31:0];
						phase_q <= 1'b1;
						idx_q <= idx_q + 6'd1;
						state_q <= S_SCANW;
					end else begin
						p1_q <= pv_rd[63:32];
						v1_q <= pv_rd[31:0];
						if (q >= p0_q && q <= $signed(pv_rd[63:32])) begin
							state_q <= S_TAN;
							phase_q <= 1'b0;
							idx_q <= idx_q - 6'd1;
						end else if (7'(idx_q) + 7'd1 >= n) begin
							out_word <= '{curve_value: '0, region: RegInterp};
							out_valid <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							p0_q <= pv_rd[63:32];
							v0_q <= pv_rd[31:0];
							idx_q <= idx_q + 6'd1;
							state_q <= S_SCANW;
						end
					end
				end
				S_TAN: begin
					idx_q <= idx_q + 6'd1;
					state_q <= S_TANW;
				end
				S_TANW: begin
					if (!phase_q) begin
						m0_q <= tg_rd[31:0];
						phase_q <= 1'b1;
					end else begin
						m1_q <= tg_rd[63:32];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (p1_q == p0_q) begin
						u_q <= '0;
						mstep_q <= '0;
						state_q <= S_MUL;
					end else if (ddone) begin
						u_q <= dquot;
						mstep_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					unique case (mstep_q)
						4'd0: begin
							t2_q <= prod[33:0];
							mstep_q <= 4'd1;
						end
						4'd1: begin
							h01_q <= rnd48(53'(3) * hx - 53'(prod[50:0]) * 53'd2);
							h10_q <= rnd48(53'(prod[50:0]) - 53'd2 * hx
								+ (53'(u_q) << 32));
							h11_q <= -rnd48(hx - 53'(prod[50:0]));
							s_q <= '0;
							mstep_q <= 4'd2;
						end
						default: begin
							h00_q <= 32'sh40000000 - h01_q;
							state_q <= S_SUM;
						end
					endcase
				end
				S_SUM: begin
					s_q <= s_q + 66'(prod);
					mstep_q <= mstep_q + 4'd1;
					if (mstep_q == 4'd5)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (res > 36'sd2147483647) begin
						out_word <= '{curve_value: 32'h7fffffff, region: RegSat};
					end else if (res < -36'sd2147483648) begin
						out_word <= '{curve_value: 32'h80000000, region: RegSat};
					end else begin
						out_word <= '{curve_value: res[31:0], region: RegInterp};
					end
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/hce_checker.sv @@
`default_nettype none
module hce_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire hce_pkg::hce_out_t out_word
);
	import hce_pkg::*;
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while output pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed under stall");
	a_region_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.region != 3'd7) else $error("bad region");
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && in_ready) && !out_valid |-> !in_ready)
		else $error("ready during evaluation");
endmodule

bind hermite_curve_evaluator_core hce_checker u_chk (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready, .out_word);
`default_nettype wire

@@ tb/hermite_curve_evaluator_core_test.sv @@
module hermite_curve_evaluator_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hce_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	hce_in_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	hce_out_t out_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:2] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	hermite_curve_evaluator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	logic signed [31:0] pos_tab [MaxPoints];
	logic signed [31:0] val_tab [MaxPoints];
	logic signed [31:0] in_tan_tab [MaxPoints];
	logic signed [31:0] out_tan_tab [MaxPoints];
	logic [6:0] num_points;
	hce_out_t expected_words [$];
	int n_errors, n_words_sent, n_words_checked, n_evals;
	bit quiet;

	function automatic logic [63:0] round_q48_q30(logic [63:0] x);
		return (x + 64'd131072) >> 18;
	endfunction

	function automatic longint floor_q30(longint x);
		if (x >= 0)
			return x >>> 30;
		return -longint'((64'(-x) + 64'h3FFF_FFFF) >> 30);
	endfunction

	function automatic longint hermite_blend(longint v0, longint m0, longint v1,
		longint m1, longint u);
		longint t2, t3, t2s, h01, h10, h11, h00, s;
		t2 = u * u;
		t3 = t2 * u;
		t2s = t2 * 65536;
		h01 = round_q48_q30(3 * t2s - 2 * t3);
		h10 = round_q48_q30(t3 - 2 * t2s + u * 64'sd4294967296);
		h11 = -longint'(round_q48_q30(t2s - t3));
		h00 = (64'sd1 <<< 30) - h01;
		s = h00 * v0 + h10 * m0 + h01 * v1 + h11 * m1;
		return floor_q30(s + (64'sd1 <<< 29));
	endfunction

	function automatic hce_out_t predict_curve(hce_in_t w);
		hce_out_t r;
		int n;
		longint q, first, last, p0, p1, den, u, v;
		r.curve_value = '0;
		if (w.req_type == ReqWrite) begin
			pos_tab[w.point_index] = w.position;
			val_tab[w.point_index] = w.point_value;
			in_tan_tab[w.point_index] = w.in_tangent;
			out_tan_tab[w.point_index] = w.out_tangent;
			r.region = RegWrite;
			return r;
		end
		n = num_points > MaxPoints ? MaxPoints : num_points;
		q = w.position;
		if (n == 0) begin
			r.region = RegEmpty;
		end else if (n == 1) begin
			r.curve_value = val_tab[0];
			r.region = RegSingle;
		end else begin
			first = pos_tab[0];
			last = pos_tab[n - 1];
			if (q > first && q < last) begin
				r.region = RegInterp;
				for (int i = 0; i + 1 < n; i++) begin
					p0 = pos_tab[i];
					p1 = pos_tab[i + 1];
					if (q >= p0 && q <= p1) begin
						den = p1 - p0;
						u = den == 0 ? 0 : ((q - p0) * 65536) / den;
						v = hermite_blend(val_tab[i], out_tan_tab[i], val_tab[i + 1],
							in_tan_tab[i + 1], u);
						if (v > 64'sd2147483647) begin
							v = 64'sd2147483647;
							r.region = RegSat;
						end else if (v < -64'sd2147483648) begin
							v = -64'sd2147483648;
							r.region = RegSat;
						end
						r.curve_value = v[31:0];
						break;
					end
				end
			end else if (q <= first) begin
				r.curve_value = val_tab[0];
				r.region = RegBelow;
			end else begin
				r.curve_value = val_tab[n - 1];
				r.region = RegAbove;
			end
		end
		return r;
	endfunction

	task automatic send_word(hce_in_t w);
		if (in_valid)
			@(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 19)) @(posedge clk);
		expected_words = {expected_words, predict_curve(w)};
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		in_valid <= 1'b0;
		n_words_sent++;
		if (w.req_type == ReqEval)
			n_evals++;
	endtask

	task automatic wait_drained();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_point_count(logic [6:0] cnt);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrPointCount;
		pwdata <= 32'(cnt);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		num_points = cnt;
	endtask

	function automatic hce_in_t point_word(int idx, logic signed [31:0] p,
		logic signed [31:0] v, logic signed [31:0] ti, logic signed [31:0] to);
		hce_in_t w;
		w.req_type = ReqWrite;
		w.point_index = 6'(idx);
		w.position = p;
		w.point_value = v;
		w.in_tangent = ti;
		w.out_tangent = to;
		return w;
	endfunction

	function automatic hce_in_t eval_word(logic signed [31:0] q);
		hce_in_t w;
		w = '0;
		w.req_type = ReqEval;
		w.position = q;
		w.point_index = 6'($urandom);
		w.point_value = $urandom;
		w.in_tangent = $urandom;
		w.out_tangent = $urandom;
		return w;
	endfunction

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
		endcase
	endfunction

	// non-decreasing table of n points, written in random slot order
	task automatic load_ascending(int n, bit wide);
		logic signed [31:0] p;
		int order [$];
		logic signed [31:0] ps [MaxPoints];
		p = wide ? 32'sh8000_0000 + $urandom_range(0, 1000) : $signed($urandom_range(0, 65536)) - 32768;
		for (int i = 0; i < n; i++) begin
			ps[i] = p;
			if ($urandom_range(0, 9) != 0)
				p = p + (wide ? $urandom_range(1, 32'h7FFF_FFFF / (n + 1)) :
					$urandom_range(1, 32'h0003_0000));
			order = {order, i};
		end
		order.shuffle();
		foreach (order[k])
			send_word(point_word(order[k], ps[order[k]], rand_val(), rand_val(), rand_val()));
	endtask

	function automatic logic signed [31:0] query_in_range(int n);
		longint lo, hi;
		lo = pos_tab[0];
		hi = pos_tab[n - 1];
		if ($urandom_range(0, 7) == 0)
			return pos_tab[$urandom_range(0, n - 1)];
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		if (hi <= lo)
			return 32'(lo + $signed($urandom_range(0, 20)) - 10);
		return 32'(lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1)));
	endfunction

	task automatic test_empty_and_single();
		write_point_count(7'd0);
		send_word(eval_word(32'sh8000_0000));
		send_word(eval_word(32'sh7FFF_FFFF));
		send_word(point_word(0, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
		write_point_count(7'd1);
		send_word(eval_word(32'sh0000_0000));
		send_word(eval_word(32'sh7FFF_FFFF));
	endtask

	task automatic test_segment_cases();
		send_word(point_word(1, 32'sh0002_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
		send_word(point_word(2, 32'sh0002_0000, 32'sh0001_0000, 32'sh0, 32'sh0));
		send_word(point_word(3, 32'sh7FFF_FFFF, 32'sh0003_0000, 32'sh0001_0000, 32'sh0));
		write_point_count(7'd4);
		send_word(eval_word(32'sh8000_0000));
		send_word(eval_word(32'sh0001_0000));
		send_word(eval_word(32'sh0001_8000));
		send_word(eval_word(32'sh0001_4000));
		send_word(eval_word(32'sh0002_0000));
		send_word(eval_word(32'sh4000_0000));
		send_word(eval_word(32'sh7FFF_FFFF));
		// count beyond table size clamps
		send_word(point_word(63, 32'sh7FFF_FFFF, 32'sh1234_5678, 32'sh0, 32'sh0));
		for (int i = 4; i < 63; i++)
			send_word(point_word(i, 32'sh7FFF_FFFF, i, 0, 0));
		write_point_count(7'd127);
		send_word(eval_word(32'sh7FFF_FFFF));
		send_word(eval_word(32'sh0001_C000));
		// descending ends, then non-ascending interior
		send_word(point_word(0, 32'sh0100_0000, 32'sh0000_1111, 0, 0));
		send_word(point_word(1, 32'sh8000_0000, 32'sh0000_2222, 0, 0));
		write_point_count(7'd2);
		send_word(eval_word(32'sh0100_0000));
		send_word(eval_word(32'sh0000_0000));
		send_word(point_word(1, 32'sh0300_0000, 32'sh0000_2222, 0, 0));
		send_word(point_word(2, 32'sh0400_0000, 32'sh0000_3333, 0, 0));
		send_word(point_word(0, 32'sh0000_0000, 32'sh0000_1111, 0, 0));
		send_word(point_word(1, 32'sh0500_0000, 32'sh0000_2222, 0, 0));
		write_point_count(7'd3);
		send_word(eval_word(32'sh0200_0000));
	endtask

	task automatic test_random_curves(int budget, bit no_idle);
		int n, cnt;
		quiet = no_idle;
		cnt = 0;
		while (cnt < budget) begin
			n = $urandom_range(0, 3) == 0 ? $urandom_range(2, 64) : $urandom_range(2, 8);
			load_ascending(n, $urandom_range(0, 3) == 0);
			cnt += n;
			if ($urandom_range(0, 9) == 0)
				write_point_count($urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127)));
			else
				write_point_count(7'(n));
			n = num_points > MaxPoints ? MaxPoints : num_points;
			if (num_points > n)
				for (int i = 0; i < MaxPoints; i++)
					if (pos_tab[i] === 'x)
						send_word(point_word(i, 32'sh7FFF_FFFF, rand_val(), 0, 0));
			repeat ($urandom_range(4, 12)) begin
				send_word(eval_word(query_in_range(n)));
				cnt++;
			end
			if ($urandom_range(0, 4) == 0)
				wait_drained();
		end
		quiet = 1'b0;
	endtask

	always @(posedge clk) begin
		if (quiet)
			out_ready <= 1'b1;
		else if ($urandom_range(0, 7) == 0)
			out_ready <= ~out_ready;
		else if (!out_ready && $urandom_range(0, 3) == 0)
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		hce_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected output word %h", out_word);
			end else begin
				e = expected_words.pop_front();
				n_words_checked++;
				if (out_word.curve_value !== e.curve_value || out_word.region !== e.region) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: exp value %h region %0d, got value %h region %0d",
							e.curve_value, e.region, out_word.curve_value, out_word.region);
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("hermite_curve_evaluator_core_test: done, errors");
		$finish;
	end

	initial begin
		num_points = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_single();
		test_segment_cases();
		test_random_curves(800, 1'b0);
		test_random_curves(150, 1'b1);
		wait_drained();
		$display("sent %0d words (%0d evaluations), checked %0d results",
			n_words_sent, n_evals, n_words_checked);
		$display("covered empty, single, clamped ends, zero-width, saturation, bad order");
		if (n_errors == 0 && expected_words.size() == 0)
			$display("hermite_curve_evaluator_core_test: done, clean");
		else
			$display("hermite_curve_evaluator_core_test: done, errors");
		$finish;
	end
endmodule
